@@ sv/bloom_filter_with_hit_window_assert.svh @@
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Concurrent check macros for the bloom filter block, removable as a set.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_WITH_HIT_WINDOW_ASSERT_SVH
`define BLOOM_FILTER_WITH_HIT_WINDOW_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check on every edge out of reset
`define BFHW_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check on every edge, reset included
`define BFHW_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define BFHW_ASSERT(name, prop, msg)
`define BFHW_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

@@ sv/bfhw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter package
// Item types, command codes, register indexes and hash constants.
// ----------------------------------------------------------------------------
package bfhw_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_PROBE  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] REG_SEED_A     = 2'd0;
   localparam logic [1:0] REG_SEED_B     = 2'd1;
   localparam logic [1:0] REG_SEED_C     = 2'd2;
   localparam logic [1:0] REG_WINDOW_LEN = 2'd3;

   localparam logic [31:0] HASH_MULT   = 32'h045d_9f3b;
   localparam int          SEED_W      = 16;
   localparam int          SEED_CNT_W  = 4;
   localparam int          COUNT_W     = 24;
   localparam int          SUM_W       = 32;
   localparam int          WLEN_W      = 7;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] window_hits;
      logic signed [31:0] window_probes;
   } rsp_type;

endpackage

@@ sv/bloom_filter_with_hit_window.sv @@
// Insert and probe: hash issue, drain, then result register; one bit index
//   enters the hash pipeline per cycle and the filter memory port takes one
//   access per cycle. Tick: ring memory read, then write. Clear: straight to result.
// A new item is accepted only once the previous result is registered, so items
//   never overlap. Reset: synchronous; a clearing pass over all FILTER_BITS
//   entries zeroes the filter memory; ring entries clear via valid bits.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter with hit window
// Hashed bit store with insert/probe, period counters and a windowed sum ring.
// ----------------------------------------------------------------------------
module bloom_filter_with_hit_window
   import bfhw_pkg::*;
#(
   parameter int NUM_HASH     = 10,
   parameter int FILTER_BITS  = 16384,
   parameter int WINDOW_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   `include "bloom_filter_with_hit_window_assert.svh"

   localparam int IDX_W = $clog2(FILTER_BITS);
   localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / FILTER_BITS);
   localparam logic [31:0] FB32  = 32'(FILTER_BITS);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_HASH    = 3'd2;
   localparam logic [2:0] S_DRAIN   = 3'd3;
   localparam logic [2:0] S_TICK_RD = 3'd4;
   localparam logic [2:0] S_TICK_WR = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   function automatic logic [POS_W-1:0] len_m1(input logic [WLEN_W-1:0] wl);
      logic [POS_W-1:0] r;
      if (wl == '0) begin
         r = '0;
      end else if (32'(wl) > WINDOW_DEPTH) begin
         r = POS_W'(WINDOW_DEPTH - 1);
      end else begin
         r = POS_W'(wl - 7'd1);
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // control and configuration
   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      clr_cnt_ff;
   logic [63:0]           seed_a_ff, seed_b_ff, seed_c_ff;
   logic [WLEN_W-1:0]     window_length_ff;
   logic [1:0]            cmd_ff;
   logic [63:0]           key_ff;
   logic [SEED_CNT_W-1:0] issue_cnt_ff;
   logic [SEED_CNT_W-1:0] done_cnt_ff;
   logic                  hit_acc_ff;
   logic                  out_hit_ff;
   logic                  fin;
   logic                  accept;

   // statistics
   logic [COUNT_W-1:0]    period_hits_ff, period_probes_ff;
   logic [SUM_W-1:0]      sum_hits_ff, sum_probes_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [WINDOW_DEPTH-1:0] ring_valid_ff;
   logic [2*COUNT_W-1:0]  ring_mem [WINDOW_DEPTH];
   logic [2*COUNT_W-1:0]  ring_rd_ff;
   logic [COUNT_W-1:0]    old_hits, old_probes;

   // hash pipeline
   logic [8:0]            vld_ff;
   logic [63:0]           x0_ff, x2_ff, x4_ff;
   logic [58:0]           pl1_ff, pl3_ff;
   logic [31:0]           ph1_ff, ph3_ff;
   logic [31:0]           h5_ff, h6_ff, h7_ff;
   logic [63:0]           prod6_ff;
   logic [31:0]           qf7_ff;
   logic [IDX_W-1:0]      idx8_ff;
   logic [191:0]          seed_all;
   logic [SEED_W-1:0]     seed_cur;
   logic [63:0]           y0, y2, x4_mix;
   logic [31:0]           r7;
   logic [IDX_W:0]        r7_n;

   // filter memory
   logic                  filt_mem [FILTER_BITS];
   logic                  rd_bit_ff;
   logic                  rd_vld_ff;

   // output register
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign fin       = (state_ff == S_DRAIN) && rd_vld_ff
                      && (done_cnt_ff == SEED_CNT_W'(NUM_HASH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(FILTER_BITS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.command) inside
                  CMD_INSERT, CMD_PROBE: state_in = S_HASH;
                  CMD_TICK:              state_in = S_TICK_RD;
                  CMD_CLEAR:             state_in = S_RESP;
                  default:               state_in = S_RESP;
               endcase
            end
         end
         S_HASH: begin
            if (issue_cnt_ff == SEED_CNT_W'(NUM_HASH - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (fin) state_in = S_RESP;
         end
         S_TICK_RD: state_in = S_TICK_WR;
         S_TICK_WR: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff        <= '0;
         seed_b_ff        <= '0;
         seed_c_ff        <= '0;
         window_length_ff <= WLEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SEED_A:     seed_a_ff <= csr_wdata;
            REG_SEED_B:     seed_b_ff <= csr_wdata;
            REG_SEED_C:     seed_c_ff <= csr_wdata;
            REG_WINDOW_LEN: window_length_ff <= csr_wdata[WLEN_W-1:0];
            default:        ;
         endcase
      end
   end

   // item capture and hash issue
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data.command;
         key_ff <= req_data.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff <= '0;
         done_cnt_ff  <= '0;
         hit_acc_ff   <= 1'b0;
      end else if (accept) begin
         issue_cnt_ff <= '0;
         done_cnt_ff  <= '0;
         hit_acc_ff   <= 1'b1;
      end else begin
         if (state_ff == S_HASH) issue_cnt_ff <= issue_cnt_ff + 1'b1;
         if (rd_vld_ff) begin
            done_cnt_ff <= done_cnt_ff + 1'b1;
            hit_acc_ff  <= hit_acc_ff & rd_bit_ff;
         end
      end
   end

   assign seed_all = {seed_c_ff, seed_b_ff, seed_a_ff};
   assign seed_cur = seed_all[{issue_cnt_ff, 4'b0000} +: SEED_W];

   assign y0     = x0_ff ^ (x0_ff >> 16);
   assign y2     = x2_ff ^ (x2_ff >> 16);
   assign x4_mix = x4_ff ^ (x4_ff >> 16);
   assign r7     = h7_ff - qf7_ff;
   assign r7_n   = r7[IDX_W:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], (state_ff == S_HASH)};
      end
   end

   // two shift-xor-multiply rounds, each split into two half products
   always_ff @(posedge clock) begin
      x0_ff    <= {key_ff[31:0], 32'd0} ^ {48'd0, seed_cur};
      pl1_ff   <= 59'(y0[31:0]) * 59'(HASH_MULT);
      ph1_ff   <= y0[63:32] * HASH_MULT;
      x2_ff    <= 64'(pl1_ff) + {ph1_ff, 32'd0};
      pl3_ff   <= 59'(y2[31:0]) * 59'(HASH_MULT);
      ph3_ff   <= y2[63:32] * HASH_MULT;
      x4_ff    <= 64'(pl3_ff) + {ph3_ff, 32'd0};
      h5_ff    <= x4_mix[31:0];
      // modulo by reciprocal: estimate is low by at most one
      prod6_ff <= 64'(h5_ff) * 64'(RECIP);
      h6_ff    <= h5_ff;
      qf7_ff   <= prod6_ff[63:32] * FB32;
      h7_ff    <= h6_ff;
      idx8_ff  <= (r7_n >= (IDX_W + 1)'(FILTER_BITS))
                  ? IDX_W'(r7_n - (IDX_W + 1)'(FILTER_BITS)) : IDX_W'(r7_n);
   end

   // filter memory: clearing pass, insert sets, probe reads
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         filt_mem[clr_cnt_ff] <= 1'b0;
      end else if (vld_ff[8] && (cmd_ff == CMD_INSERT)) begin
         filt_mem[idx8_ff] <= 1'b1;
      end
      rd_bit_ff <= filt_mem[idx8_ff] | (cmd_ff == CMD_INSERT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[8];
      end
   end

   // ring memory, read at the current slot before the tick write
   always_ff @(posedge clock) begin
      if (state_ff == S_TICK_RD) ring_rd_ff <= ring_mem[pos_ff];
      if (state_ff == S_TICK_WR) ring_mem[pos_ff] <= {period_hits_ff, period_probes_ff};
   end

   assign old_hits   = ring_valid_ff[pos_ff] ? ring_rd_ff[2*COUNT_W-1:COUNT_W] : '0;
   assign old_probes = ring_valid_ff[pos_ff] ? ring_rd_ff[COUNT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_hits_ff   <= '0;
         period_probes_ff <= '0;
         sum_hits_ff      <= '0;
         sum_probes_ff    <= '0;
         pos_ff           <= len_m1(WLEN_RESET);
         ring_valid_ff    <= '0;
         out_hit_ff       <= 1'b0;
      end else begin
         if (csr_we && (csr_index == REG_WINDOW_LEN)) begin
            ring_valid_ff <= '0;
            pos_ff        <= len_m1(csr_wdata[WLEN_W-1:0]);
         end
         if (accept) out_hit_ff <= 1'b0;
         if (accept && (req_data.command == CMD_CLEAR)) begin
            period_hits_ff   <= '0;
            period_probes_ff <= '0;
            sum_hits_ff      <= '0;
            sum_probes_ff    <= '0;
         end
         if (fin && (cmd_ff == CMD_PROBE)) begin
            period_probes_ff <= sat_inc(period_probes_ff);
            if (hit_acc_ff & rd_bit_ff) begin
               period_hits_ff <= sat_inc(period_hits_ff);
               out_hit_ff     <= 1'b1;
            end
         end
         if (state_ff == S_TICK_WR) begin
            sum_hits_ff   <= sum_hits_ff - SUM_W'(old_hits) + SUM_W'(period_hits_ff);
            sum_probes_ff <= sum_probes_ff - SUM_W'(old_probes)
                             + SUM_W'(period_probes_ff);
            ring_valid_ff[pos_ff] <= 1'b1;
            pos_ff <= (pos_ff == '0) ? len_m1(window_length_ff) : pos_ff - 1'b1;
            period_hits_ff   <= '0;
            period_probes_ff <= '0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.hit           <= out_hit_ff;
         rsp_data_ff.window_hits   <= sum_hits_ff;
         rsp_data_ff.window_probes <= sum_probes_ff;
      end
   end

   `BFHW_ASSERT(a_pos_in_window, pos_ff <= len_m1(window_length_ff), "ring slot past window")
   `BFHW_ASSERT(a_no_rsp_in_clear, (state_ff == S_CLEAR) |-> !rsp_valid_ff, "result in clear")
   `BFHW_ASSERT(a_rd_in_hash, rd_vld_ff |-> (state_ff == S_HASH || state_ff == S_DRAIN), "stray bit")
   `BFHW_ASSERT(a_rsp_from_resp, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP), "stray result")

endmodule
